@@ src/sddf_pkg.sv @@
// Shared types and constants for the signed decimal digit formatter.
`default_nettype none
package sddf_pkg;

    localparam int DISP_W  = 3;
    localparam int NUM_W   = 32;
    localparam int POINT_W = 4;
    localparam int ACT_W   = 2;
    localparam int SLOT_W  = 3;
    localparam int DIGIT_W = 4;
    localparam int MIN_W   = 4;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd0;
    localparam logic [ACT_W-1:0] ACT_DIGIT = 2'd1;
    localparam logic [ACT_W-1:0] ACT_MINUS = 2'd2;

    // Reciprocal of ten for a 32-bit dividend: q = (x * RECIP10) >> RECIP10_SHIFT.
    localparam logic [NUM_W-1:0] RECIP10       = 32'hCCCC_CCCD;
    localparam int               RECIP10_SHIFT = 35;

    // Classified job handed from the front end to the sequencer.
    typedef struct packed {
        logic [DISP_W-1:0] disp;
        logic              neg;
        logic [NUM_W-1:0]  mag;
        logic              point_valid;
        logic [SLOT_W-1:0] point;
        logic [MIN_W-1:0]  min_digits;
    } t_job;

endpackage
`default_nettype wire

@@ src/signed_decimal_digit_formatter_core.sv @@
// Top level of the signed decimal digit formatter: front end, job queue, sequencer.
// The first output beat (clear) is registered by the sequencer once the job leaves the queue.
// Throughput: one output beat per cycle while i_out_ready holds; an item of n actions (clear, up to
//   DIGIT_COUNT digits, optional minus if a slot is left) holds the sequencer for n beats,
//   at most 9 at the default, set by the one-digit-per-cycle divide-by-ten loop unless stalled.
// Reset: synchronous active-low i_rst_n empties the queue and output register.
`default_nettype none
module signed_decimal_digit_formatter_core
    import sddf_pkg::*;
#(
    parameter int DIGIT_COUNT = 8
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // input channel
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire logic [DISP_W-1:0]         i_display_index,
    input  wire logic signed [NUM_W-1:0]   i_number,
    input  wire logic signed [POINT_W-1:0] i_point_position,
    // output channel
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output logic [ACT_W-1:0]               o_action,
    output logic [DISP_W-1:0]              o_target_display,
    output logic [SLOT_W-1:0]              o_digit_position,
    output logic [DIGIT_W-1:0]             o_digit_value,
    output logic                           o_point_on,
    output logic                           o_last
);

    // front end -> queue
    logic push;
    t_job push_job;
    logic full;

    // queue -> sequencer
    logic job_valid;
    t_job job;
    logic pop;

    // Front end: splits sign from magnitude (most negative value becomes 2^31),
    // decodes point position into padding length and point-lit flag.
    sddf_front u_front (
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_display_index  (i_display_index),
        .i_number         (i_number),
        .i_point_position (i_point_position),
        .i_full           (full),
        .o_push           (push),
        .o_job            (push_job)
    );

    // Short queue lets input beats land while the sequencer is busy.
    sddf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .o_valid (job_valid),
        .i_pop   (pop),
        .o_job   (job)
    );

    // Sequencer: clear beat on load, then one digit per cycle unless stalled (LSD first),
    // padding to the point slot, capped at DIGIT_COUNT slots, then minus if room.
    sddf_back #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_job_valid      (job_valid),
        .i_job            (job),
        .o_pop            (pop),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_action         (o_action),
        .o_target_display (o_target_display),
        .o_digit_position (o_digit_position),
        .o_digit_value    (o_digit_value),
        .o_point_on       (o_point_on),
        .o_last           (o_last)
    );

endmodule
`default_nettype wire

@@ src/sddf_front.sv @@
// Front end: accepts input beats and classifies sign, magnitude and padding.
`default_nettype none
module sddf_front
    import sddf_pkg::*;
(
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire logic [DISP_W-1:0]         i_display_index,
    input  wire logic signed [NUM_W-1:0]   i_number,
    input  wire logic signed [POINT_W-1:0] i_point_position,
    input  wire logic                      i_full,
    output logic                           o_push,
    output t_job                           o_job
);

    logic [NUM_W-1:0] raw;

    always_comb begin
        raw                = i_number;
        o_in_ready         = ~i_full;
        o_push             = i_in_valid & ~i_full;
        o_job.disp         = i_display_index;
        o_job.neg          = raw[NUM_W-1];
        // two's complement negate; the most negative value maps to 2^31
        o_job.mag          = raw[NUM_W-1] ? (~raw + 32'd1) : raw;
        o_job.point_valid  = ~i_point_position[POINT_W-1];
        o_job.point        = i_point_position[SLOT_W-1:0];
        o_job.min_digits   = o_job.point_valid ? (MIN_W'(o_job.point) + 4'd1) : 4'd1;
    end

endmodule
`default_nettype wire

@@ src/sddf_queue.sv @@
// Two-entry job queue between the front end and the sequencer.
`default_nettype none
module sddf_queue
    import sddf_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    output logic      o_full,
    output logic      o_valid,
    input  wire logic i_pop,
    output t_job      o_job
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_job             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_comb begin
        o_full  = (r_cnt == CNT_W'(QUEUE_DEPTH));
        o_valid = (r_cnt != '0);
        o_job   = r_mem[r_rd];
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_cnt   = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule
`default_nettype wire

@@ src/sddf_back.sv @@
// Sequencer: emits clear, one digit per cycle (reciprocal divide) unless stalled, then minus.
`default_nettype none
module sddf_back
    import sddf_pkg::*;
#(
    parameter int DIGIT_COUNT = 8
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_job_valid,
    input  wire t_job                i_job,
    output logic                     o_pop,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic [ACT_W-1:0]         o_action,
    output logic [DISP_W-1:0]        o_target_display,
    output logic [SLOT_W-1:0]        o_digit_position,
    output logic [DIGIT_W-1:0]       o_digit_value,
    output logic                     o_point_on,
    output logic                     o_last
);

    localparam int PW = $clog2(DIGIT_COUNT + 1);
    localparam int CW = (PW > MIN_W) ? PW : MIN_W;

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_DIGIT = 2'd1;
    localparam logic [1:0] PH_MINUS = 2'd2;

    logic [1:0]          r_phase, n_phase;
    t_job                r_job, n_job;
    logic [NUM_W-1:0]    r_mag, n_mag;
    logic [PW-1:0]       r_pos, n_pos;
    logic                r_ov, n_ov;
    logic [ACT_W-1:0]    r_act, n_act;
    logic [DISP_W-1:0]   r_disp, n_disp;
    logic [SLOT_W-1:0]   r_slot, n_slot;
    logic [DIGIT_W-1:0]  r_dig, n_dig;
    logic                r_pt, n_pt;
    logic                r_last, n_last;

    logic                adv;
    logic [2*NUM_W-1:0]  prod;
    logic [NUM_W-1:0]    quo;
    logic [NUM_W-1:0]    rem;
    logic [PW-1:0]       pos_inc;
    logic                room;
    logic                more;

    always_comb begin
        adv     = ~r_ov | i_out_ready;
        prod    = (2*NUM_W)'(r_mag) * (2*NUM_W)'(RECIP10);
        quo     = NUM_W'(prod >> RECIP10_SHIFT);
        rem     = r_mag - ((quo << 3) + (quo << 1));
        pos_inc = r_pos + 1'b1;
        room    = CW'(pos_inc) < CW'(DIGIT_COUNT);
        more    = ((quo != '0) || (CW'(pos_inc) < CW'(r_job.min_digits))) && room;

        n_phase = r_phase;
        n_job   = r_job;
        n_mag   = r_mag;
        n_pos   = r_pos;
        n_ov    = r_ov & ~i_out_ready;
        n_act   = r_act;
        n_disp  = r_disp;
        n_slot  = r_slot;
        n_dig   = r_dig;
        n_pt    = r_pt;
        n_last  = r_last;
        o_pop   = 1'b0;

        if (adv) begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (i_job_valid) begin
                        // clear beat goes out as the job is loaded
                        o_pop   = 1'b1;
                        n_job   = i_job;
                        n_mag   = i_job.mag;
                        n_pos   = '0;
                        n_phase = PH_DIGIT;
                        n_ov    = 1'b1;
                        n_act   = ACT_CLEAR;
                        n_disp  = i_job.disp;
                        n_slot  = '0;
                        n_dig   = '0;
                        n_pt    = 1'b0;
                        n_last  = 1'b0;
                    end
                end
                PH_DIGIT: begin
                    n_ov   = 1'b1;
                    n_act  = ACT_DIGIT;
                    n_disp = r_job.disp;
                    n_slot = SLOT_W'(r_pos);
                    n_dig  = DIGIT_W'(rem);
                    n_pt   = r_job.point_valid && (CW'(r_pos) == CW'(r_job.point));
                    n_mag  = quo;
                    n_pos  = pos_inc;
                    if (more) begin
                        n_last = 1'b0;
                    end else if (r_job.neg && room) begin
                        n_last  = 1'b0;
                        n_phase = PH_MINUS;
                    end else begin
                        n_last  = 1'b1;
                        n_phase = PH_IDLE;
                    end
                end
                PH_MINUS: begin
                    n_ov    = 1'b1;
                    n_act   = ACT_MINUS;
                    n_disp  = r_job.disp;
                    n_slot  = SLOT_W'(r_pos);
                    n_dig   = '0;
                    n_pt    = 1'b0;
                    n_last  = 1'b1;
                    n_phase = PH_IDLE;
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end

        o_out_valid      = r_ov;
        o_action         = r_act;
        o_target_display = r_disp;
        o_digit_position = r_slot;
        o_digit_value    = r_dig;
        o_point_on       = r_pt;
        o_last           = r_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job  <= n_job;
        r_mag  <= n_mag;
        r_pos  <= n_pos;
        r_act  <= n_act;
        r_disp <= n_disp;
        r_slot <= n_slot;
        r_dig  <= n_dig;
        r_pt   <= n_pt;
        r_last <= n_last;
    end

endmodule
`default_nettype wire
